### hw/rtl/rgbconv_pkg.sv
// ----------------------------------------------------------------------------
// rgbconv_pkg
// Shared types and constants for the RGBA 3x3 clamped convolution core.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = COL_W + 1;
  localparam int HGT_W      = ROW_W + 1;
  localparam int COEF_W     = 48;
  localparam int CSUM_W     = 36;
  localparam int ASUM_W     = 28;
  localparam int ADDR_W     = 6;

  localparam logic [2:0] REG_COEF_TOP = 3'd0;
  localparam logic [2:0] REG_COEF_MID = 3'd1;
  localparam logic [2:0] REG_COEF_BOT = 3'd2;
  localparam logic [2:0] REG_ALPHA    = 3'd3;
  localparam logic [2:0] REG_BYPASS   = 3'd4;
  localparam logic [2:0] REG_WIDTH    = 3'd5;
  localparam logic [2:0] REG_HEIGHT   = 3'd6;

  typedef struct packed {
    logic [COEF_W-1:0] coef_top;
    logic [COEF_W-1:0] coef_mid;
    logic [COEF_W-1:0] coef_bot;
    logic              alpha_mode;
    logic              bypass;
    logic [WID_W-1:0]  width;
    logic [HGT_W-1:0]  height;
    logic              restart;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       shift;
    logic       pick;
    logic       run;
    logic [1:0] emit_k;
    logic       emit_last;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] flags;
    logic       acc_done;
    logic       bypass;
  } status_t;

endpackage

### hw/rtl/rgbconv_ctrl.sv
// ----------------------------------------------------------------------------
// rgbconv_ctrl
// Sequencer: takes an item, fetches the line stores, then walks the pending
// results through the kernel datapath (skipped in bypass) and the output register.
// ----------------------------------------------------------------------------
module rgbconv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  rgbconv_pkg::status_t status,
  output rgbconv_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_PICK  = 6'b000100,
    S_MAC   = 6'b001000,
    S_LOAD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [3:0] pending, pending_next;
  logic [1:0] k;
  logic [3:0] rem;

  always_comb begin
    if (pending[0]) begin
      k = 2'd0;
    end else if (pending[1]) begin
      k = 2'd1;
    end else if (pending[2]) begin
      k = 2'd2;
    end else begin
      k = 2'd3;
    end
    rem = pending & ~(4'b0001 << k);
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next    = state;
    pending_next  = pending;
    cmd           = '0;
    cmd.emit_k    = k;
    cmd.emit_last = (rem == 4'd0);
    cmd.run       = !status.bypass;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.shift    = 1'b1;
        pending_next = status.flags;
        state_next   = S_PICK;
      end
      S_PICK: begin
        if (pending == 4'd0) begin
          state_next = S_IDLE;
        end else begin
          cmd.pick     = 1'b1;
          pending_next = rem;
          state_next   = status.bypass ? S_LOAD : S_MAC;
        end
      end
      S_MAC: begin
        if (status.acc_done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_PICK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 4'd0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

endmodule

### hw/rtl/rgbconv_dp.sv
// ----------------------------------------------------------------------------
// rgbconv_dp
// Datapath: frame counters, two line stores, 3x3 window, tap-serial
// multiply-accumulate and the output register.
// ----------------------------------------------------------------------------
module rgbconv_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  rgbconv_pkg::cfg_t                   cfg,
  input  rgbconv_pkg::cmd_t                   cmd,
  output rgbconv_pkg::status_t                status,
  input  logic [7:0]                          red_in,
  input  logic [7:0]                          green_in,
  input  logic [7:0]                          blue_in,
  input  logic [7:0]                          alpha_in,
  output logic signed [rgbconv_pkg::CSUM_W-1:0] red_sum,
  output logic signed [rgbconv_pkg::CSUM_W-1:0] green_sum,
  output logic signed [rgbconv_pkg::CSUM_W-1:0] blue_sum,
  output logic signed [rgbconv_pkg::ASUM_W-1:0] alpha_sum,
  output logic [rgbconv_pkg::COL_W-1:0]       out_col,
  output logic [rgbconv_pkg::ROW_W-1:0]       out_row,
  output logic                                run_last
);

  localparam int CW = rgbconv_pkg::COL_W;
  localparam int RW = rgbconv_pkg::ROW_W;
  localparam int SW = rgbconv_pkg::CSUM_W;
  localparam int AW = rgbconv_pkg::ASUM_W;

  logic [31:0]   line0 [rgbconv_pkg::MAX_WIDTH];
  logic [31:0]   line1 [rgbconv_pkg::MAX_WIDTH];
  logic [31:0]   rd0, rd1;
  logic [31:0]   win [9];
  logic [CW-1:0] col_count, c_cl, c_lat, wm1;
  logic [RW-1:0] row_count, r_cl, r_lat, hm1;
  logic [31:0]   pix_lat;
  logic [3:0]    flags;
  logic [1:0]    emit_k;
  logic          emit_last;
  logic [1:0]    tj, ti;
  logic          running;
  logic [1:0]    rs, cs;
  logic [3:0]    widx;
  logic [31:0]   px;
  logic [rgbconv_pkg::COEF_W-1:0] crow;
  logic signed [15:0] wsel;

  logic [15:0]        pa_ra, pa_ga, pa_ba;
  logic [7:0]         pa_a;
  logic signed [15:0] pa_w;
  logic               pa_valid, pa_last;
  logic signed [SW-1:0] acc_r, acc_g, acc_b;
  logic signed [AW-1:0] acc_a;
  logic               acc_done;

  assign wm1 = CW'(cfg.width - 1'b1);
  assign hm1 = RW'(cfg.height - 1'b1);
  assign c_cl = ({1'b0, col_count} >= cfg.width) ? wm1 : col_count;
  assign r_cl = ({1'b0, row_count} >= cfg.height) ? hm1 : row_count;

  assign status.flags    = flags;
  assign status.acc_done = acc_done;
  assign status.bypass   = cfg.bypass;

  // frame position and item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg.restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd.accept) begin
      if (c_cl == wm1) begin
        col_count <= '0;
        row_count <= (r_cl == hm1) ? '0 : r_cl + 1'b1;
      end else begin
        col_count <= c_cl + 1'b1;
        row_count <= r_cl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_lat    <= c_cl;
      r_lat    <= r_cl;
      pix_lat  <= {alpha_in, blue_in, green_in, red_in};
      flags[0] <= (r_cl != '0) && (c_cl != '0);
      flags[1] <= (r_cl != '0) && (c_cl == wm1);
      flags[2] <= (r_cl != '0) && (r_cl == hm1) && (c_cl != '0);
      flags[3] <= (r_cl != '0) && (r_cl == hm1) && (c_cl == wm1);
      rd0      <= line0[c_cl];
      rd1      <= line1[c_cl];
    end
    if (cmd.shift) begin
      line1[c_lat] <= rd0;
      line0[c_lat] <= pix_lat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 9; n++) begin
        win[n] <= '0;
      end
    end else if (cmd.shift) begin
      for (int j = 0; j < 3; j++) begin
        win[j*3]   <= win[j*3+1];
        win[j*3+1] <= win[j*3+2];
      end
      win[2] <= rd1;
      win[5] <= rd0;
      win[8] <= pix_lat;
    end
  end

  // window tap selection with edge clamping
  always_comb begin
    if (emit_k[1]) begin
      rs = (tj == 2'd0) ? 2'd1 : 2'd2;
    end else begin
      rs = (tj == 2'd0) ? ((r_lat == RW'(1)) ? 2'd1 : 2'd0) : tj;
    end
    if (emit_k[0]) begin
      cs = (ti == 2'd0) ? 2'd1 : 2'd2;
    end else begin
      cs = (ti == 2'd0) ? ((c_lat == CW'(1)) ? 2'd1 : 2'd0) : ti;
    end
    widx = {rs, 1'b0} + {2'b00, rs} + {2'b00, cs};
    px   = win[widx];
    case (tj)
      2'd0:    crow = cfg.coef_top;
      2'd1:    crow = cfg.coef_mid;
      default: crow = cfg.coef_bot;
    endcase
    case (ti)
      2'd0:    wsel = crow[15:0];
      2'd1:    wsel = crow[31:16];
      default: wsel = crow[47:32];
    endcase
  end

  // tap sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (cmd.pick) begin
      running <= cmd.run;
    end else if (running && tj == 2'd2 && ti == 2'd2) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      emit_k    <= cmd.emit_k;
      emit_last <= cmd.emit_last;
      tj        <= cmd.run ? 2'd0 : 2'd1;
      ti        <= cmd.run ? 2'd0 : 2'd1;
    end else if (running) begin
      if (ti == 2'd2) begin
        ti <= 2'd0;
        if (tj != 2'd2) begin
          tj <= tj + 1'b1;
        end
      end else begin
        ti <= ti + 1'b1;
      end
    end
  end

  // stage A: premultiply by alpha, pick the coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      pa_valid <= 1'b0;
      pa_last  <= 1'b0;
    end else begin
      pa_valid <= running;
      pa_last  <= running && tj == 2'd2 && ti == 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    pa_ra <= px[7:0]   * px[31:24];
    pa_ga <= px[15:8]  * px[31:24];
    pa_ba <= px[23:16] * px[31:24];
    pa_a  <= px[31:24];
    pa_w  <= wsel;
  end

  // stage B: weight and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
    end else begin
      acc_done <= pa_valid && pa_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
      acc_a <= '0;
    end else if (pa_valid) begin
      acc_r <= acc_r + SW'($signed({1'b0, pa_ra}) * pa_w);
      acc_g <= acc_g + SW'($signed({1'b0, pa_ga}) * pa_w);
      acc_b <= acc_b + SW'($signed({1'b0, pa_ba}) * pa_w);
      acc_a <= acc_a + (cfg.alpha_mode ? AW'($signed({1'b0, pa_a}) * pa_w)
                                       : AW'({pa_a, 12'd0}));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cfg.bypass) begin
        red_sum   <= SW'({px[7:0], 20'd0})   - SW'({px[7:0], 12'd0});
        green_sum <= SW'({px[15:8], 20'd0})  - SW'({px[15:8], 12'd0});
        blue_sum  <= SW'({px[23:16], 20'd0}) - SW'({px[23:16], 12'd0});
        alpha_sum <= AW'({px[31:24], 12'd0});
      end else begin
        red_sum   <= acc_r;
        green_sum <= acc_g;
        blue_sum  <= acc_b;
        alpha_sum <= acc_a;
      end
      out_col  <= emit_k[0] ? c_lat : c_lat - 1'b1;
      out_row  <= emit_k[1] ? r_lat : r_lat - 1'b1;
      run_last <= emit_last;
    end
  end

endmodule

### hw/rtl/rgba_3x3_convolution_clamped_core.sv
// ----------------------------------------------------------------------------
// rgba_3x3_convolution_clamped_core
// 3x3 RGBA convolution with clamp-to-edge, alpha premultiply and register
// port.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid/in_stall, red/green/blue/alpha_in  in
//  output    out_valid/out_stall, *_sum, out_col/row     out
//  config    psel/penable/pwrite/paddr/pwdata/prdata     in/out
//
//  An item takes accept, fetch and window shift, then a closing pick; each result
//  takes a pick, the nine taps on the shared MAC, stages A and B, a load and an out
//  state (bypass goes from pick to load), plus any out_stall time. Up to 4 results.
//  Synchronous reset clears control, window and config registers; line stores are
//  not cleared. The next item is taken once the last result is delivered.
// ----------------------------------------------------------------------------
module rgba_3x3_convolution_clamped_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rgbconv_pkg::ADDR_W-1:0]       paddr,
  input  logic [63:0]                          pwdata,
  output logic [63:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           red_in,
  input  logic [7:0]                           green_in,
  input  logic [7:0]                           blue_in,
  input  logic [7:0]                           alpha_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rgbconv_pkg::CSUM_W-1:0] red_sum,
  output logic signed [rgbconv_pkg::CSUM_W-1:0] green_sum,
  output logic signed [rgbconv_pkg::CSUM_W-1:0] blue_sum,
  output logic signed [rgbconv_pkg::ASUM_W-1:0] alpha_sum,
  output logic [rgbconv_pkg::COL_W-1:0]        out_col,
  output logic [rgbconv_pkg::ROW_W-1:0]        out_row,
  output logic                                 run_last
);

  localparam int WW = rgbconv_pkg::WID_W;
  localparam int HW = rgbconv_pkg::HGT_W;

  logic [47:0]   coef_top, coef_mid, coef_bot;
  logic          alpha_mode, bypass;
  logic [11:0]   image_width;
  logic [12:0]   image_height;
  logic          wr;
  logic [2:0]    idx;
  rgbconv_pkg::cfg_t    cfg;
  rgbconv_pkg::cmd_t    cmd;
  rgbconv_pkg::status_t status;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top     <= '0;
      coef_mid     <= 48'd268435456;
      coef_bot     <= '0;
      alpha_mode   <= 1'b0;
      bypass       <= 1'b0;
      image_width  <= 12'd640;
      image_height <= 13'd480;
    end else if (wr) begin
      case (idx)
        rgbconv_pkg::REG_COEF_TOP: coef_top     <= pwdata[47:0];
        rgbconv_pkg::REG_COEF_MID: coef_mid     <= pwdata[47:0];
        rgbconv_pkg::REG_COEF_BOT: coef_bot     <= pwdata[47:0];
        rgbconv_pkg::REG_ALPHA:    alpha_mode   <= pwdata[0];
        rgbconv_pkg::REG_BYPASS:   bypass       <= pwdata[0];
        rgbconv_pkg::REG_WIDTH:    image_width  <= pwdata[11:0];
        rgbconv_pkg::REG_HEIGHT:   image_height <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      rgbconv_pkg::REG_COEF_TOP: prdata = {16'd0, coef_top};
      rgbconv_pkg::REG_COEF_MID: prdata = {16'd0, coef_mid};
      rgbconv_pkg::REG_COEF_BOT: prdata = {16'd0, coef_bot};
      rgbconv_pkg::REG_ALPHA:    prdata = {63'd0, alpha_mode};
      rgbconv_pkg::REG_BYPASS:   prdata = {63'd0, bypass};
      rgbconv_pkg::REG_WIDTH:    prdata = {52'd0, image_width};
      rgbconv_pkg::REG_HEIGHT:   prdata = {51'd0, image_height};
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.coef_top   = coef_top;
    cfg.coef_mid   = coef_mid;
    cfg.coef_bot   = coef_bot;
    cfg.alpha_mode = alpha_mode;
    cfg.bypass     = bypass;
    if (image_width < 12'd2) begin
      cfg.width = WW'(2);
    end else if (image_width > 12'(rgbconv_pkg::MAX_WIDTH)) begin
      cfg.width = WW'(rgbconv_pkg::MAX_WIDTH);
    end else begin
      cfg.width = image_width;
    end
    if (image_height < 13'd2) begin
      cfg.height = HW'(2);
    end else if (image_height > 13'(rgbconv_pkg::MAX_HEIGHT)) begin
      cfg.height = HW'(rgbconv_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = image_height;
    end
    cfg.restart = wr && (idx == rgbconv_pkg::REG_WIDTH || idx == rgbconv_pkg::REG_HEIGHT);
  end

  rgbconv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rgbconv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .red_sum   (red_sum),
    .green_sum (green_sum),
    .blue_sum  (blue_sum),
    .alpha_sum (alpha_sum),
    .out_col   (out_col),
    .out_row   (out_row),
    .run_last  (run_last)
  );

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item taken while a result is pending");

  a_fetch_follows_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.shift) else $error("window shift missing after item");

  a_load_after_pick: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.pick && !cmd.accept) else $error("load overlaps pick");

endmodule
